FILE: src/fsp_pkg.sv
`timescale 1ns / 1ps

package fsp_pkg;

  localparam logic [30:0] SatMax = 31'h7FFF_FFFF;

  // flag bit positions
  localparam int unsigned FbAlt    = 0;
  localparam int unsigned FbZero   = 1;
  localparam int unsigned FbLeft   = 2;
  localparam int unsigned FbSpace  = 3;
  localparam int unsigned FbSign   = 4;
  localparam int unsigned FbGroup  = 5;
  localparam int unsigned FbBinary = 6;
  localparam int unsigned NumFlags = 7;

  localparam logic [7:0] ChSharp = 8'h23;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChApos  = 8'd39;
  localparam logic [7:0] ChBigB  = 8'h42;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChH     = 8'h68;
  localparam logic [7:0] ChL     = 8'h6C;
  localparam logic [7:0] ChBigL  = 8'h4C;

  localparam logic [2:0] LenInt      = 3'd0;
  localparam logic [2:0] LenChar     = 3'd1;
  localparam logic [2:0] LenShort    = 3'd2;
  localparam logic [2:0] LenLong     = 3'd3;
  localparam logic [2:0] LenLongLong = 3'd4;
  localparam logic [2:0] LenLongDbl  = 3'd5;

  typedef struct packed {
    logic [NumFlags-1:0] flags;
    logic [30:0]         field_width;
    logic signed [31:0]  prec_value;
    logic [2:0]          length_code;
    logic [7:0]          conv_char;
  } res_t;

  // acc * 10 + d, clipped to the largest positive 32-bit value
  function automatic logic [30:0] acc_digit(input logic [30:0] acc, input logic [3:0] d);
    logic [34:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {31'd0, d};
    if (v > {4'd0, SatMax}) begin
      return SatMax;
    end
    return v[30:0];
  endfunction

endpackage

FILE: src/fsp_if.sv
`timescale 1ns / 1ps

interface fsp_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         ch;
  logic signed [31:0] star_arg;

  modport source (output valid, output ch, output star_arg, input ready);
  modport sink (input valid, input ch, input star_arg, output ready);
endinterface

interface fsp_out_if;
  logic               valid;
  logic               ready;
  logic               flag_alt;
  logic               flag_zero;
  logic               flag_left;
  logic               flag_space;
  logic               flag_sign;
  logic               flag_group;
  logic               flag_binary;
  logic [30:0]        field_width;
  logic signed [31:0] prec_value;
  logic [2:0]         length_code;
  logic [7:0]         conv_char;

  modport source (
    output valid, output flag_alt, output flag_zero, output flag_left, output flag_space,
    output flag_sign, output flag_group, output flag_binary, output field_width,
    output prec_value, output length_code, output conv_char, input ready
  );
  modport sink (
    input valid, input flag_alt, input flag_zero, input flag_left, input flag_space,
    input flag_sign, input flag_group, input flag_binary, input field_width,
    input prec_value, input length_code, input conv_char, output ready
  );
endinterface

FILE: src/format_spec_parser_unit.sv
`timescale 1ns / 1ps

// channel  | dir | transaction
// in_i     | in  | one spec character ch plus star_arg
// res_o    | out | parsed fields, one per terminating character
//
// one character per cycle while in_i.ready is high; the parse state updates at the edge that takes it
// a terminating character registers its result in the output register, or in the skid if that holds one not yet taken
// a one-entry skid behind the output register keeps in_i ready while a result waits
// in_i.ready drops only when both the output register and the skid hold results
// asynchronous active-low reset returns the parser to the flags phase, outputs empty

module format_spec_parser_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  fsp_in_if.sink    in_i,
  fsp_out_if.source res_o
);
  import fsp_pkg::*;

  typedef enum logic [2:0] {
    PhFlags,
    PhWidthDig,
    PhAfterWidth,
    PhDot,
    PhPrecDig,
    PhLength
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [NumFlags-1:0] flags_q, flags_d;
  logic [30:0]         width_q, width_d;
  logic signed [31:0]  prec_q, prec_d;
  logic [1:0]          h_cnt_q, h_cnt_d;
  logic [1:0]          l_cnt_q, l_cnt_d;
  logic                big_l_q, big_l_d;

  res_t out_q, skid_q, res_new;
  logic out_valid_q, skid_valid_q;
  logic emit;
  logic push, pop;

  logic [7:0]  ch;
  logic [31:0] star;
  logic [31:0] star_neg;
  logic        is_dig;

  assign ch       = in_i.ch;
  assign star     = in_i.star_arg;
  assign star_neg = 32'd0 - star;
  assign is_dig   = (ch >= ChZero) && (ch <= ChNine);

  always_comb begin
    phase_e ph;
    logic   done;
    ph      = phase_q;
    done    = 1'b0;
    emit    = 1'b0;
    flags_d = flags_q;
    width_d = width_q;
    prec_d  = prec_q;
    h_cnt_d = h_cnt_q;
    l_cnt_d = l_cnt_q;
    big_l_d = big_l_q;

    if (ph == PhFlags) begin
      done = 1'b1;
      if (ch == ChSharp) begin
        flags_d[FbAlt] = 1'b1;
      end else if (ch == ChZero) begin
        if (!flags_q[FbLeft]) flags_d[FbZero] = 1'b1;
      end else if (ch == ChMinus) begin
        flags_d[FbLeft] = 1'b1;
        flags_d[FbZero] = 1'b0;
      end else if (ch == ChSpace) begin
        if (!flags_q[FbSign]) flags_d[FbSpace] = 1'b1;
      end else if (ch == ChPlus) begin
        flags_d[FbSign]  = 1'b1;
        flags_d[FbSpace] = 1'b0;
      end else if (ch == ChApos) begin
        flags_d[FbGroup] = 1'b1;
      end else if (ch == ChBigB) begin
        flags_d[FbBinary] = 1'b1;
      end else if ((ch >= ChOne) && (ch <= ChNine)) begin
        width_d = {27'd0, ch[3:0]};
        ph      = PhWidthDig;
      end else if (ch == ChStar) begin
        if (star[31]) begin
          flags_d[FbLeft] = 1'b1;
          // the most negative value has no positive twin, clip it
          width_d = star_neg[31] ? SatMax : star_neg[30:0];
        end else begin
          width_d = star[30:0];
        end
        ph = PhAfterWidth;
      end else begin
        done = 1'b0;
        ph   = PhAfterWidth;
      end
    end

    if (!done && ph == PhWidthDig) begin
      if (is_dig) begin
        width_d = acc_digit(width_q, ch[3:0]);
        done    = 1'b1;
      end else begin
        ph = PhAfterWidth;
      end
    end

    if (!done && ph == PhAfterWidth) begin
      if (ch == ChDot) begin
        ph   = PhDot;
        done = 1'b1;
      end else begin
        ph = PhLength;
      end
    end

    if (!done && ph == PhDot) begin
      done = 1'b1;
      if (ch == ChDot) begin
        ph = PhDot;
      end else if (is_dig) begin
        prec_d = {28'd0, ch[3:0]};
        ph     = PhPrecDig;
      end else if (ch == ChStar) begin
        prec_d = star[31] ? -32'sd1 : star;
        ph     = PhLength;
      end else begin
        prec_d = 32'sd0;
        ph     = PhLength;
        done   = 1'b0;
      end
    end

    if (!done && ph == PhPrecDig) begin
      if (is_dig) begin
        // precision is never negative while digits accumulate
        prec_d = {1'b0, acc_digit(prec_q[30:0], ch[3:0])};
        done   = 1'b1;
      end else begin
        ph = PhLength;
      end
    end

    if (!done) begin
      ph = PhLength;
      if (ch == ChH) begin
        if (h_cnt_q != 2'd3) h_cnt_d = h_cnt_q + 2'd1;
      end else if (ch == ChL) begin
        if (l_cnt_q != 2'd3) l_cnt_d = l_cnt_q + 2'd1;
      end else if (ch == ChBigL) begin
        big_l_d = 1'b1;
      end else begin
        emit = 1'b1;
      end
    end

    res_new.flags       = flags_d;
    res_new.field_width = width_d;
    res_new.prec_value  = prec_d;
    res_new.conv_char   = ch;
    if (h_cnt_q == 2'd0 && l_cnt_q == 2'd1) begin
      res_new.length_code = LenLong;
    end else if (l_cnt_q == 2'd1) begin
      res_new.length_code = LenLong;
    end else if (h_cnt_q == 2'd2) begin
      res_new.length_code = LenChar;
    end else if (h_cnt_q == 2'd1) begin
      res_new.length_code = LenShort;
    end else if (l_cnt_q >= 2'd2) begin
      res_new.length_code = LenLongLong;
    end else if (big_l_q) begin
      res_new.length_code = LenLongDbl;
    end else begin
      res_new.length_code = LenInt;
    end

    if (emit) begin
      phase_d = PhFlags;
      flags_d = '0;
      width_d = '0;
      prec_d  = -32'sd1;
      h_cnt_d = 2'd0;
      l_cnt_d = 2'd0;
      big_l_d = 1'b0;
    end else begin
      phase_d = ph;
    end
  end

  assign in_i.ready = !skid_valid_q;
  assign push       = in_i.valid && in_i.ready && emit;
  assign pop        = out_valid_q && res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhFlags;
      flags_q <= '0;
      width_q <= '0;
      prec_q  <= -32'sd1;
      h_cnt_q <= 2'd0;
      l_cnt_q <= 2'd0;
      big_l_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      phase_q <= phase_d;
      flags_q <= flags_d;
      width_q <= width_d;
      prec_q  <= prec_d;
      h_cnt_q <= h_cnt_d;
      l_cnt_q <= l_cnt_d;
      big_l_q <= big_l_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        out_q        <= skid_q;
        skid_valid_q <= 1'b0;
      end else if (push) begin
        out_q <= res_new;
      end else begin
        out_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_q) begin
        skid_q       <= res_new;
        skid_valid_q <= 1'b1;
      end else begin
        out_q       <= res_new;
        out_valid_q <= 1'b1;
      end
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.flag_alt    = out_q.flags[FbAlt];
  assign res_o.flag_zero   = out_q.flags[FbZero];
  assign res_o.flag_left   = out_q.flags[FbLeft];
  assign res_o.flag_space  = out_q.flags[FbSpace];
  assign res_o.flag_sign   = out_q.flags[FbSign];
  assign res_o.flag_group  = out_q.flags[FbGroup];
  assign res_o.flag_binary = out_q.flags[FbBinary];
  assign res_o.field_width = out_q.field_width;
  assign res_o.prec_value  = out_q.prec_value;
  assign res_o.length_code = out_q.length_code;
  assign res_o.conv_char   = out_q.conv_char;

endmodule

FILE: src/fsp_checker.sv
`timescale 1ns / 1ps

module fsp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [7:0]  in_ch_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  out_conv_char_i,
  input logic [30:0] out_width_i,
  input logic [31:0] out_prec_i
);
  import fsp_pkg::*;

  logic term_ch;
  // characters that no phase consumes always end the spec
  assign term_ch = (in_ch_i == 8'h64) || (in_ch_i == 8'h78) || (in_ch_i == 8'h73);

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_conv_char_i)
      && $stable(out_width_i) && $stable(out_prec_i))
    else $error("stalled result changed");

  a_ready_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no pending result");

  a_term_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && term_ch && (!out_valid_i || out_ready_i)
      |=> out_valid_i && (out_conv_char_i == $past(in_ch_i)))
    else $error("terminating character gave no result");

  a_term_no_prec_after_reset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && term_ch && (!out_valid_i || out_ready_i)
      ##1 in_valid_i && in_ready_i && term_ch && out_ready_i
      |=> out_prec_i == 32'hFFFF_FFFF && out_width_i == 31'd0)
    else $error("parse state not cleared after result");

endmodule

bind format_spec_parser_unit fsp_checker u_fsp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_ch_i        (in_i.ch),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .out_conv_char_i(res_o.conv_char),
  .out_width_i    (res_o.field_width),
  .out_prec_i     (res_o.prec_value)
);

FILE: tb/sv/tb_format_spec_parser_unit.sv
`timescale 1ns / 1ps

module tb_format_spec_parser_unit;
  import fsp_pkg::*;

  localparam longint ValueCeil  = 64'sd2147483647;
  localparam int     RandomGoal = 1350;
  localparam int     CycleLimit = 300000;
  localparam int     TailCycles = 8;
  localparam int     ReportMax  = 10;

  typedef enum logic [2:0] {
    PhFlags,
    PhWidthDig,
    PhAfterWidth,
    PhDot,
    PhPrecDig,
    PhLen
  } parse_phase_e;

  typedef struct {
    logic [7:0]         ch;
    logic signed [31:0] star;
  } spec_char_t;

  logic clk_i;
  logic rst_ni;

  fsp_in_if  in_if ();
  fsp_out_if res_if ();

  format_spec_parser_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .res_o  (res_if)
  );

  // parser state as predicted
  parse_phase_e       phase_q;
  logic [6:0]         flag_q;
  logic [30:0]        width_q;
  logic signed [31:0] prec_q;
  logic [1:0]         h_cnt_q;
  logic [1:0]         l_cnt_q;
  logic               big_l_q;

  spec_char_t char_queue[$];
  res_t       expected_results[$];

  int burst_left = 1;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_count = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void clear_parse_state();
    phase_q = PhFlags;
    flag_q  = '0;
    width_q = '0;
    prec_q  = -32'sd1;
    h_cnt_q = '0;
    l_cnt_q = '0;
    big_l_q = 1'b0;
  endfunction

  function automatic longint add_digit(input longint acc, input logic [7:0] ch);
    longint v;
    v = acc * 10 + longint'(ch[3:0]);
    return (v > ValueCeil) ? ValueCeil : v;
  endfunction

  function automatic logic [2:0] length_code_of();
    if (l_cnt_q == 2'd1) begin
      return LenLong;
    end
    if (h_cnt_q == 2'd2) begin
      return LenChar;
    end
    if (h_cnt_q == 2'd1) begin
      return LenShort;
    end
    if (l_cnt_q >= 2'd2) begin
      return LenLongLong;
    end
    if (big_l_q) begin
      return LenLongDbl;
    end
    return LenInt;
  endfunction

  // advances the predicted parse by one character, returns 1 when the spec ends
  function automatic bit parse_char(input logic [7:0] ch, input logic signed [31:0] star,
                                    output res_t r);
    longint mag;
    bit     is_dig;
    is_dig = (ch >= ChZero) && (ch <= ChNine);
    r = '0;
    if (phase_q == PhFlags) begin
      if (ch == ChSharp) begin
        flag_q[FbAlt] = 1'b1;
        return 1'b0;
      end
      if (ch == ChZero) begin
        if (!flag_q[FbLeft]) flag_q[FbZero] = 1'b1;
        return 1'b0;
      end
      if (ch == ChMinus) begin
        flag_q[FbLeft] = 1'b1;
        flag_q[FbZero] = 1'b0;
        return 1'b0;
      end
      if (ch == ChSpace) begin
        if (!flag_q[FbSign]) flag_q[FbSpace] = 1'b1;
        return 1'b0;
      end
      if (ch == ChPlus) begin
        flag_q[FbSign]  = 1'b1;
        flag_q[FbSpace] = 1'b0;
        return 1'b0;
      end
      if (ch == ChApos) begin
        flag_q[FbGroup] = 1'b1;
        return 1'b0;
      end
      if (ch == ChBigB) begin
        flag_q[FbBinary] = 1'b1;
        return 1'b0;
      end
      if (ch >= ChOne && ch <= ChNine) begin
        width_q = {27'd0, ch[3:0]};
        phase_q = PhWidthDig;
        return 1'b0;
      end
      if (ch == ChStar) begin
        mag = star;
        if (mag < 0) begin
          // magnitude of the most negative value does not fit, clip it
          mag = -mag;
          if (mag > ValueCeil) mag = ValueCeil;
          flag_q[FbLeft] = 1'b1;
        end
        width_q = mag[30:0];
        phase_q = PhAfterWidth;
        return 1'b0;
      end
      phase_q = PhAfterWidth;
    end
    if (phase_q == PhWidthDig) begin
      if (is_dig) begin
        mag = add_digit(longint'(width_q), ch);
        width_q = mag[30:0];
        return 1'b0;
      end
      phase_q = PhAfterWidth;
    end
    if (phase_q == PhAfterWidth) begin
      if (ch == ChDot) begin
        phase_q = PhDot;
        return 1'b0;
      end
      phase_q = PhLen;
    end
    if (phase_q == PhDot) begin
      if (ch == ChDot) begin
        return 1'b0;
      end
      if (is_dig) begin
        prec_q  = {28'd0, ch[3:0]};
        phase_q = PhPrecDig;
        return 1'b0;
      end
      if (ch == ChStar) begin
        prec_q  = (star < 0) ? -32'sd1 : star;
        phase_q = PhLen;
        return 1'b0;
      end
      // a dot with nothing after it means precision zero
      prec_q  = 32'sd0;
      phase_q = PhLen;
    end
    if (phase_q == PhPrecDig) begin
      if (is_dig) begin
        mag = add_digit(longint'(prec_q), ch);
        prec_q = mag[31:0];
        return 1'b0;
      end
      phase_q = PhLen;
    end
    if (ch == ChH) begin
      if (h_cnt_q != 2'd3) h_cnt_q = h_cnt_q + 2'd1;
      return 1'b0;
    end
    if (ch == ChL) begin
      if (l_cnt_q != 2'd3) l_cnt_q = l_cnt_q + 2'd1;
      return 1'b0;
    end
    if (ch == ChBigL) begin
      big_l_q = 1'b1;
      return 1'b0;
    end
    r.flags       = flag_q;
    r.field_width = width_q;
    r.prec_value  = prec_q;
    r.length_code = length_code_of();
    r.conv_char   = ch;
    clear_parse_state();
    return 1'b1;
  endfunction

  task automatic push_char(input logic [7:0] ch, input logic signed [31:0] star);
    spec_char_t c;
    c.ch   = ch;
    c.star = star;
    char_queue.push_back(c);
  endtask

  function automatic logic signed [31:0] rand_star();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 32'($urandom_range(0, 40));
      3: return 32'sd0 - 32'($urandom_range(1, 40));
      4: return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  // stimulus and end of run
  initial begin : stim_proc
    int         n;
    int         total;
    logic [7:0] term;
    rst_ni         = 1'b0;
    clear_parse_state();

    // every flag, zero after minus, space after plus
    push_char(ChSharp, $urandom());
    push_char(ChZero, $urandom());
    push_char(ChMinus, $urandom());
    push_char(ChZero, $urandom());
    push_char(ChSpace, $urandom());
    push_char(ChPlus, $urandom());
    push_char(ChSpace, $urandom());
    push_char(ChApos, $urandom());
    push_char(ChBigB, $urandom());
    push_char("d", $urandom());
    // most negative star width, repeated dots, negative star precision, long
    push_char(ChStar, 32'sh8000_0000);
    push_char(ChDot, $urandom());
    push_char(ChDot, $urandom());
    push_char(ChStar, -32'sd5);
    push_char(ChL, $urandom());
    push_char("x", $urandom());
    // overlong width, bare dot, long double
    push_char("3", $urandom());
    for (int i = 0; i < 9; i++) push_char(ChZero, $urandom());
    push_char(ChDot, $urandom());
    push_char(ChBigL, $urandom());
    push_char("f", $urandom());
    // top byte ends an empty spec
    push_char(8'hFF, 32'sh7FFF_FFFF);

    total = char_queue.size() + RandomGoal;
    while (char_queue.size() < total) begin
      if ($urandom_range(0, 99) < 15) begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) push_char(8'($urandom()), $urandom());
      end else begin
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 6))
            0: push_char(ChSharp, $urandom());
            1: push_char(ChZero, $urandom());
            2: push_char(ChMinus, $urandom());
            3: push_char(ChSpace, $urandom());
            4: push_char(ChPlus, $urandom());
            5: push_char(ChApos, $urandom());
            default: push_char(ChBigB, $urandom());
          endcase
        end
        case ($urandom_range(0, 5))
          2, 3: begin
            push_char(8'(ChOne + $urandom_range(0, 8)), $urandom());
            n = $urandom_range(0, 2);
            for (int i = 0; i < n; i++) push_char(8'(ChZero + $urandom_range(0, 9)), $urandom());
          end
          4: push_char(ChStar, rand_star());
          5: begin
            push_char(8'(ChOne + $urandom_range(0, 8)), $urandom());
            n = $urandom_range(8, 11);
            for (int i = 0; i < n; i++) push_char(8'(ChZero + $urandom_range(0, 9)), $urandom());
          end
          default: ;
        endcase
        if ($urandom_range(0, 1) == 1) begin
          push_char(ChDot, $urandom());
          if ($urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 2);
            for (int i = 0; i < n; i++) push_char(ChDot, $urandom());
          end
          case ($urandom_range(0, 4))
            1, 2: begin
              n = $urandom_range(1, 3);
              for (int i = 0; i < n; i++) push_char(8'(ChZero + $urandom_range(0, 9)), $urandom());
            end
            3: push_char(ChStar, rand_star());
            4: begin
              n = $urandom_range(9, 12);
              for (int i = 0; i < n; i++) push_char(8'(ChZero + $urandom_range(0, 9)), $urandom());
            end
            default: ;
          endcase
        end
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 4))
            0, 1: push_char(ChH, $urandom());
            2, 3: push_char(ChL, $urandom());
            default: push_char(ChBigL, $urandom());
          endcase
        end
        case ($urandom_range(0, 7))
          0: term = "d";
          1: term = "s";
          2: term = "x";
          3: term = "f";
          4: term = "%";
          5: term = "p";
          default: begin
            // any byte that no phase can take
            do begin
              term = 8'($urandom());
            end while ((term >= ChZero && term <= ChNine) || term == ChDot ||
                       term == ChStar || term == ChSharp || term == ChMinus ||
                       term == ChSpace || term == ChPlus || term == ChApos ||
                       term == ChBigB || term == ChH || term == ChL || term == ChBigL);
          end
        endcase
        push_char(term, $urandom());
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (char_queue.size() != 0 || expected_results.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("format_spec_parser_unit regression: pass");
    end else begin
      $display("format_spec_parser_unit regression: fail");
    end
    $finish;
  end

  // character driver, bursts with random gaps
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    res_t res;
    logic fire;
    logic next_valid;
    if (!rst_ni) begin
      in_if.valid    <= 1'b0;
      in_if.ch       <= '0;
      in_if.star_arg <= '0;
    end else begin
      fire = in_if.valid && in_if.ready;
      if (fire) begin
        if (parse_char(char_queue[0].ch, char_queue[0].star, res)) begin
          expected_results.push_back(res);
        end
        void'(char_queue.pop_front());
      end
      next_valid = 1'b0;
      if (in_if.valid && !fire) begin
        next_valid = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (char_queue.size() != 0) begin
        next_valid = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          if ($urandom_range(0, 9) == 0) begin
            burst_left = $urandom_range(50, 200);
          end else begin
            burst_left = $urandom_range(1, 24);
          end
          gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
        end
      end
      in_if.valid <= next_valid;
      if (char_queue.size() != 0) begin
        in_if.ch       <= char_queue[0].ch;
        in_if.star_arg <= char_queue[0].star;
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin : mon_proc
    res_t got;
    res_t want;
    logic next_ready;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got.flags[FbAlt]    = res_if.flag_alt;
        got.flags[FbZero]   = res_if.flag_zero;
        got.flags[FbLeft]   = res_if.flag_left;
        got.flags[FbSpace]  = res_if.flag_space;
        got.flags[FbSign]   = res_if.flag_sign;
        got.flags[FbGroup]  = res_if.flag_group;
        got.flags[FbBinary] = res_if.flag_binary;
        got.field_width     = res_if.field_width;
        got.prec_value      = res_if.prec_value;
        got.length_code     = res_if.length_code;
        got.conv_char       = res_if.conv_char;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= ReportMax) begin
            $display("unexpected result transaction: flags=%b width=%0d prec=%0d len=%0d conv=%h",
                     got.flags, got.field_width, got.prec_value, got.length_code,
                     got.conv_char);
          end
        end else begin
          want = expected_results.pop_front();
          if (got.flags !== want.flags || got.field_width !== want.field_width ||
              got.prec_value !== want.prec_value || got.length_code !== want.length_code ||
              got.conv_char !== want.conv_char) begin
            mismatch_count++;
            if (mismatch_count <= ReportMax) begin
              $display("result mismatch: exp flags=%b width=%0d prec=%0d len=%0d conv=%h",
                       want.flags, want.field_width, want.prec_value, want.length_code,
                       want.conv_char);
              $display("                 got flags=%b width=%0d prec=%0d len=%0d conv=%h",
                       got.flags, got.field_width, got.prec_value, got.length_code,
                       got.conv_char);
            end
          end
        end
      end
      stall_count++;
      if (stall_count >= 50) begin
        stall_count = 0;
        stall_mode  = $urandom_range(0, 3);
      end
      case (stall_mode)
        1: next_ready = ($urandom_range(0, 3) != 0);
        2: next_ready = ($urandom_range(0, 3) == 0);
        3: next_ready = ~res_if.ready;
        default: next_ready = 1'b1;
      endcase
      res_if.ready <= next_ready;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("format_spec_parser_unit regression: fail");
      $finish;
    end
  end

endmodule
